// ===== design/frp_pkg.sv =====
// Shared types and constants for the frame replacement policy core.
// No dependencies; included by scoped reference from every module.
`default_nettype none

package frp_pkg;

  localparam int unsigned NumFrames = 32;
  localparam int unsigned FrameW    = 5;
  localparam int unsigned CountW    = FrameW + 1;
  localparam int unsigned OwnerW    = 8;
  localparam int unsigned PageW     = 16;
  localparam int unsigned TimeW     = 32;

  localparam logic [1:0] ModeAlloc   = 2'd0;
  localparam logic [1:0] ModeRelease = 2'd1;
  localparam logic [1:0] ModeTouch   = 2'd2;
  localparam logic [1:0] ModeShare   = 2'd3;

  localparam logic [1:0] PolicyFifo  = 2'd0;
  localparam logic [1:0] PolicyLru   = 2'd1;
  localparam logic [1:0] PolicyClock = 2'd2;

  localparam logic [1:0] StatusDone   = 2'd0;
  localparam logic [1:0] StatusVictim = 2'd1;
  localparam logic [1:0] StatusNone   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE,
    ST_FIFO,
    ST_LRU,
    ST_CLOCK,
    ST_DROP,
    ST_REPL,
    ST_DONE
  } state_e;

  // Control broadcast to every cell of the queue chain.
  typedef struct packed {
    logic              shift;
    logic              wr;
    logic [FrameW-1:0] wr_idx;
    logic [FrameW-1:0] ins;
  } qctl_t;

endpackage

`default_nettype wire

// ===== design/frp_qcell.sv =====
// One slot of the FIFO queue chain: holds a frame number and takes its
// upper neighbor's value on a shift. Depends on frp_pkg.
`default_nettype none

module frp_qcell #(
  parameter int unsigned Idx = 0
) (
  input  wire                        clk_i,
  input  frp_pkg::qctl_t             ctl_i,
  input  wire [frp_pkg::FrameW-1:0]  nbr_i,
  output logic [frp_pkg::FrameW-1:0] q_o
);

  logic [frp_pkg::FrameW-1:0] slot_q, slot_d;

  always_comb begin
    slot_d = slot_q;
    if (ctl_i.shift) begin
      slot_d = nbr_i;
    end
    if (ctl_i.wr && (ctl_i.wr_idx == frp_pkg::FrameW'(Idx))) begin
      slot_d = ctl_i.ins;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign q_o = slot_q;

endmodule

`default_nettype wire

// ===== design/frame_replacement_policy_core.sv =====
// Allocate scans the frames in index order for a free one; with no free frame it then runs
// the LRU scan, the FIFO queue walk or the clock sweep, then a replacement step if a victim is found.
// Release of a queued frame walks the queue; touch and mark-shared need no walk.
// One request at a time; the sequential frame scan and the queue walk set the rate.
// Reset (rst_ni low, asynchronous) clears all frame flags, timestamps, queue count, hand and
// policy; no clearing pass is needed, the block is ready right after reset.
`default_nettype none

module frame_replacement_policy_core (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // Configuration write channel (policy register).
  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire [1:0]                  cfg_data_i,
  // Request channel.
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire [1:0]                  mode_i,
  input  wire [7:0]                  owner_id_i,
  input  wire [15:0]                 virtual_page_i,
  input  wire [4:0]                  excluded_frame_i,
  input  wire                        exclude_valid_i,
  input  wire [4:0]                  target_frame_i,
  input  wire [31:0]                 current_time_i,
  // Result channel.
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic [4:0]                 frame_o,
  output logic [1:0]                 status_o,
  output logic [7:0]                 victim_owner_o,
  output logic [15:0]                victim_page_o
);

  localparam int unsigned N  = frp_pkg::NumFrames;
  localparam int unsigned FW = frp_pkg::FrameW;
  localparam int unsigned CW = frp_pkg::CountW;

  // Control state.
  frp_pkg::state_e state_q, state_d;
  logic [1:0]      policy_q;
  logic [N-1:0]    occ_q, ref_q, shr_q, inq_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   rem_q;
  logic [FW-1:0]   hand_q;
  logic [FW-1:0]   idx_q;
  logic [CW-1:0]   cnt_q;
  logic            found_q;
  logic [FW-1:0]   vic_q;
  logic            out_valid_q;

  // Latched request and working payload.
  logic [frp_pkg::OwnerW-1:0] owner_q;
  logic [frp_pkg::PageW-1:0]  page_q;
  logic [FW-1:0]            ex_q;
  logic                     exv_q;
  logic [FW-1:0]            tgt_q;
  logic [frp_pkg::TimeW-1:0]  now_q;
  logic [frp_pkg::TimeW-1:0]  best_t_q;
  logic [FW-1:0]            res_frame_q;
  logic [1:0]               res_status_q;
  logic [frp_pkg::OwnerW-1:0] res_vown_q;
  logic [frp_pkg::PageW-1:0]  res_vpage_q;
  logic [FW-1:0]            out_frame_q;
  logic [1:0]               out_status_q;
  logic [frp_pkg::OwnerW-1:0] out_vown_q;
  logic [frp_pkg::PageW-1:0]  out_vpage_q;

  // Per-frame tables. Owner and page are only read after they were written.
  logic [frp_pkg::OwnerW-1:0] owner_mem [N];
  logic [frp_pkg::PageW-1:0]  page_mem [N];
  logic [frp_pkg::TimeW-1:0]  time_q [N];

  // Queue chain: slot 0 is the head of the FIFO order.
  frp_pkg::qctl_t qctl;
  logic [FW-1:0]  qv [N];
  logic [FW-1:0]  qn [N];

  for (genvar j = 0; j < N; j++) begin : g_q
    if (j == N - 1) begin : g_last
      assign qn[j] = '0;
    end else begin : g_mid
      assign qn[j] = qv[j+1];
    end
    frp_qcell #(.Idx(j)) u_cell (
      .clk_i (clk_i),
      .ctl_i (qctl),
      .nbr_i (qn[j]),
      .q_o   (qv[j])
    );
  end

  // Decisions taken this cycle; shared by the next-state, control and datapath logic.
  logic          accept, load_out;
  logic [FW-1:0] head;
  logic          head_ex;
  logic          fifo_drop, fifo_take, fifo_keep, fifo_fin;
  logic          drop_hit, drop_keep;
  logic          free_hit, free_last, free_push;
  logic          lru_elig, lru_better, lru_found_n, lru_last;
  logic [FW-1:0] lru_best_n;
  logic          clk_elig, clk_last;

  assign accept   = in_valid_i && !in_stall_o;
  assign load_out = !out_valid_q || !out_stall_i;
  assign head     = qv[0];
  assign head_ex  = exv_q && (head == ex_q);

  assign fifo_drop = (state_q == frp_pkg::ST_FIFO) && (rem_q != '0) && !found_q && shr_q[head];
  assign fifo_take = (state_q == frp_pkg::ST_FIFO) && (rem_q != '0) && !found_q &&
                     !shr_q[head] && !head_ex;
  assign fifo_keep = (state_q == frp_pkg::ST_FIFO) && (rem_q != '0) && !fifo_drop && !fifo_take;
  assign fifo_fin  = (state_q == frp_pkg::ST_FIFO) && (rem_q == '0);
  assign drop_hit  = (state_q == frp_pkg::ST_DROP) && (rem_q != '0) && (head == tgt_q);
  assign drop_keep = (state_q == frp_pkg::ST_DROP) && (rem_q != '0) && (head != tgt_q);

  assign free_hit  = (state_q == frp_pkg::ST_FREE) && !occ_q[idx_q];
  assign free_last = (state_q == frp_pkg::ST_FREE) && occ_q[idx_q] && (idx_q == FW'(N - 1));
  assign free_push = free_hit && !inq_q[idx_q] && (count_q < CW'(N));

  // LRU keeps the oldest eligible timestamp seen so far; ties keep the lower index.
  assign lru_elig    = !shr_q[idx_q] && !(exv_q && (idx_q == ex_q));
  assign lru_better  = lru_elig && (!found_q || (time_q[idx_q] < best_t_q));
  assign lru_found_n = found_q || lru_elig;
  assign lru_best_n  = lru_better ? idx_q : vic_q;
  assign lru_last    = (state_q == frp_pkg::ST_LRU) && (idx_q == FW'(N - 1));

  assign clk_elig = !ref_q[hand_q] && !shr_q[hand_q] && !(exv_q && (hand_q == ex_q));
  assign clk_last = cnt_q == CW'(2 * N - 1);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      frp_pkg::ST_IDLE: begin
        if (accept) begin
          if (mode_i == frp_pkg::ModeAlloc) begin
            state_d = frp_pkg::ST_FREE;
          end else if (occ_q[target_frame_i] && (mode_i == frp_pkg::ModeRelease) &&
                       inq_q[target_frame_i]) begin
            state_d = frp_pkg::ST_DROP;
          end else begin
            state_d = frp_pkg::ST_DONE;
          end
        end
      end
      frp_pkg::ST_FREE: begin
        if (free_hit) begin
          state_d = frp_pkg::ST_DONE;
        end else if (free_last) begin
          case (policy_q)
            frp_pkg::PolicyFifo:  state_d = frp_pkg::ST_FIFO;
            frp_pkg::PolicyLru:   state_d = frp_pkg::ST_LRU;
            frp_pkg::PolicyClock: state_d = frp_pkg::ST_CLOCK;
            default:              state_d = frp_pkg::ST_DONE;
          endcase
        end
      end
      frp_pkg::ST_FIFO: begin
        if (fifo_fin) begin
          state_d = found_q ? frp_pkg::ST_REPL : frp_pkg::ST_DONE;
        end
      end
      frp_pkg::ST_LRU: begin
        if (lru_last) begin
          state_d = lru_found_n ? frp_pkg::ST_REPL : frp_pkg::ST_DONE;
        end
      end
      frp_pkg::ST_CLOCK: begin
        if (clk_elig) begin
          state_d = frp_pkg::ST_REPL;
        end else if (clk_last) begin
          state_d = frp_pkg::ST_DONE;
        end
      end
      frp_pkg::ST_DROP: begin
        if (rem_q == '0) begin
          state_d = frp_pkg::ST_DONE;
        end
      end
      frp_pkg::ST_REPL: state_d = frp_pkg::ST_DONE;
      frp_pkg::ST_DONE: begin
        if (load_out) begin
          state_d = frp_pkg::ST_IDLE;
        end
      end
      default: state_d = frp_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs and the queue chain control.
  always_comb begin
    in_stall_o  = state_q != frp_pkg::ST_IDLE;
    cfg_ready_o = 1'b1;
    qctl        = '0;
    qctl.shift  = fifo_drop || fifo_take || fifo_keep || drop_hit || drop_keep;
    if (fifo_keep || drop_keep) begin
      // The head goes back to the tail, so the walk keeps the queue order.
      qctl.wr     = 1'b1;
      qctl.wr_idx = FW'(count_q - CW'(1));
      qctl.ins    = head;
    end else if (fifo_fin && found_q) begin
      qctl.wr     = 1'b1;
      qctl.wr_idx = FW'(count_q);
      qctl.ins    = vic_q;
    end else if (free_push) begin
      qctl.wr     = 1'b1;
      qctl.wr_idx = FW'(count_q);
      qctl.ins    = idx_q;
    end
  end

  // Control and flag registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frp_pkg::ST_IDLE;
      policy_q    <= frp_pkg::PolicyFifo;
      occ_q       <= '0;
      ref_q       <= '0;
      shr_q       <= '0;
      inq_q       <= '0;
      count_q     <= '0;
      rem_q       <= '0;
      hand_q      <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < N; k++) begin
        time_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        policy_q <= cfg_data_i;
      end
      if (state_q == frp_pkg::ST_DONE && load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        frp_pkg::ST_IDLE: begin
          if (accept) begin
            idx_q   <= '0;
            found_q <= 1'b0;
            cnt_q   <= '0;
            if (mode_i != frp_pkg::ModeAlloc && occ_q[target_frame_i]) begin
              case (mode_i)
                frp_pkg::ModeRelease: begin
                  occ_q[target_frame_i] <= 1'b0;
                  ref_q[target_frame_i] <= 1'b0;
                  shr_q[target_frame_i] <= 1'b0;
                  inq_q[target_frame_i] <= 1'b0;
                  rem_q                 <= count_q;
                end
                frp_pkg::ModeTouch: begin
                  ref_q[target_frame_i]  <= 1'b1;
                  time_q[target_frame_i] <= current_time_i;
                end
                default: shr_q[target_frame_i] <= 1'b1;
              endcase
            end
          end
        end
        frp_pkg::ST_FREE: begin
          if (free_hit) begin
            occ_q[idx_q] <= 1'b1;
            ref_q[idx_q] <= 1'b1;
            shr_q[idx_q] <= 1'b0;
            if (free_push) begin
              inq_q[idx_q] <= 1'b1;
              count_q      <= count_q + CW'(1);
            end
          end else if (free_last) begin
            idx_q <= '0;
            rem_q <= count_q;
            if (policy_q == frp_pkg::PolicyLru && exv_q) begin
              time_q[ex_q] <= now_q - frp_pkg::TimeW'(1);
            end
          end else begin
            idx_q <= idx_q + FW'(1);
          end
        end
        frp_pkg::ST_FIFO: begin
          if (fifo_drop || fifo_take || fifo_keep) begin
            rem_q <= rem_q - CW'(1);
          end
          if (fifo_drop) begin
            inq_q[head] <= 1'b0;
            count_q     <= count_q - CW'(1);
          end else if (fifo_take) begin
            found_q <= 1'b1;
            count_q <= count_q - CW'(1);
          end else if (fifo_fin && found_q) begin
            count_q <= count_q + CW'(1);
          end
        end
        frp_pkg::ST_LRU: begin
          found_q <= lru_found_n;
          idx_q   <= idx_q + FW'(1);
          if (lru_last && lru_found_n) begin
            time_q[lru_best_n] <= now_q;
          end
        end
        frp_pkg::ST_CLOCK: begin
          hand_q <= hand_q + FW'(1);
          cnt_q  <= cnt_q + CW'(1);
          ref_q[hand_q] <= clk_elig;
        end
        frp_pkg::ST_DROP: begin
          if (rem_q != '0) begin
            rem_q <= rem_q - CW'(1);
          end
          if (drop_hit) begin
            count_q <= count_q - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers: latched request, working values and the result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      owner_q      <= owner_id_i;
      page_q       <= virtual_page_i;
      ex_q         <= excluded_frame_i;
      exv_q        <= exclude_valid_i;
      tgt_q        <= target_frame_i;
      now_q        <= current_time_i;
      res_vown_q   <= '0;
      res_vpage_q  <= '0;
      res_frame_q  <= (mode_i == frp_pkg::ModeAlloc) ? FW'(0) : target_frame_i;
      res_status_q <= (mode_i == frp_pkg::ModeAlloc || occ_q[target_frame_i]) ?
                      frp_pkg::StatusDone : frp_pkg::StatusNone;
    end
    if (free_hit) begin
      owner_mem[idx_q] <= owner_q;
      page_mem[idx_q]  <= page_q;
      res_frame_q      <= idx_q;
    end
    if (free_last) begin
      res_status_q <= frp_pkg::StatusNone;
    end
    if (fifo_take) begin
      vic_q <= head;
    end
    if (state_q == frp_pkg::ST_LRU) begin
      vic_q <= lru_best_n;
      if (lru_better) begin
        best_t_q <= time_q[idx_q];
      end
    end
    if (state_q == frp_pkg::ST_CLOCK && clk_elig) begin
      vic_q <= hand_q;
    end
    if (state_q == frp_pkg::ST_REPL) begin
      res_vown_q       <= owner_mem[vic_q];
      res_vpage_q      <= page_mem[vic_q];
      owner_mem[vic_q] <= owner_q;
      page_mem[vic_q]  <= page_q;
      res_frame_q      <= vic_q;
      res_status_q     <= frp_pkg::StatusVictim;
    end
    if (state_q == frp_pkg::ST_DONE && load_out) begin
      out_frame_q  <= res_frame_q;
      out_status_q <= res_status_q;
      out_vown_q   <= res_vown_q;
      out_vpage_q  <= res_vpage_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_o        = out_frame_q;
  assign status_o       = out_status_q;
  assign victim_owner_o = out_vown_q;
  assign victim_page_o  = out_vpage_q;

  // Between requests the queue holds exactly the frames flagged as queued.
  a_queue_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == frp_pkg::ST_IDLE |-> $countones(inq_q) == 32'(count_q))
    else $error("queue count disagrees with queued flags");

  // A victim is only ever replaced when every frame is occupied.
  a_repl_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == frp_pkg::ST_REPL |-> &occ_q)
    else $error("replacement with a free frame available");

  // The queue never grows past the number of frames.
  a_count_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(N))
    else $error("queue count overflow");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for frame_replacement_policy_core: a directed table and
// random allocate/release/touch/share traffic, checked against an in-bench predictor.
// Depends on frp_pkg and the core; needs no other file.
`default_nettype none

module tb_top;

  // A request as it goes into the core, with the result typed in for the
  // directed rows where it is obvious (check_exp set).
  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  owner;
    logic [15:0] page;
    logic [4:0]  excl;
    logic        excl_v;
    logic [4:0]  tgt;
    logic [31:0] now;
    logic        check_exp;
    logic [4:0]  exp_frame;
    logic [1:0]  exp_status;
  } request_t;

  typedef struct {
    logic [4:0]  frame;
    logic [1:0]  status;
    logic [7:0]  vowner;
    logic [15:0] vpage;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = '0;
  logic [7:0]  owner_id_i = '0;
  logic [15:0] virtual_page_i = '0;
  logic [4:0]  excluded_frame_i = '0;
  logic        exclude_valid_i = 1'b0;
  logic [4:0]  target_frame_i = '0;
  logic [31:0] current_time_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [4:0]  frame_o;
  logic [1:0]  status_o;
  logic [7:0]  victim_owner_o;
  logic [15:0] victim_page_o;

  frame_replacement_policy_core i_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .mode_i, .owner_id_i, .virtual_page_i, .excluded_frame_i,
    .exclude_valid_i, .target_frame_i, .current_time_i,
    .out_valid_o, .out_stall_i,
    .frame_o, .status_o, .victim_owner_o, .victim_page_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor copy of the allocator state.
  logic [1:0]  pol;
  logic [7:0]  own_tab [frp_pkg::NumFrames];
  logic [15:0] page_tab[frp_pkg::NumFrames];
  logic        occ     [frp_pkg::NumFrames];
  logic        refb    [frp_pkg::NumFrames];
  logic        shr     [frp_pkg::NumFrames];
  logic [31:0] stamp   [frp_pkg::NumFrames];
  logic        queued  [frp_pkg::NumFrames];
  int          age_q[$];        // FIFO replacement order, oldest first
  int unsigned hand;

  grant_t expected_grants[$];
  grant_t typed_grants[$];
  bit     typed_valid[$];
  bit     failed = 1'b0;
  bit     quiet = 1'b0;         // no idling in the closing stretch

  function automatic void predictor_reset();
    pol = frp_pkg::PolicyFifo;
    hand = 0;
    age_q.delete();
    for (int i = 0; i < frp_pkg::NumFrames; i++) begin
      own_tab[i] = '0; page_tab[i] = '0; occ[i] = 0; refb[i] = 0;
      shr[i] = 0; stamp[i] = '0; queued[i] = 0;
    end
  endfunction

  // Computes the grant for one request and updates the predictor state.
  function automatic grant_t allocate_or_maintain(request_t r);
    grant_t g;
    int vic;
    bit got;
    int k;
    int f;
    logic [31:0] best;
    g = '{frame: '0, status: frp_pkg::StatusNone, vowner: '0, vpage: '0};
    got = 0;
    vic = 0;
    if (r.mode == frp_pkg::ModeAlloc) begin
      for (int i = 0; i < frp_pkg::NumFrames; i++) begin
        if (!occ[i]) begin
          occ[i] = 1; own_tab[i] = r.owner; page_tab[i] = r.page;
          refb[i] = 1; shr[i] = 0;
          if (!queued[i]) begin
            age_q.push_back(i);
            queued[i] = 1;
          end
          g.frame = 5'(i);
          g.status = frp_pkg::StatusDone;
          return g;
        end
      end
      if (pol == frp_pkg::PolicyFifo) begin
        // Shared frames fall out of the queue; the excluded one stays put.
        k = 0;
        while (k < age_q.size() && !got) begin
          f = age_q[k];
          if (shr[f]) begin
            age_q.delete(k);
            queued[f] = 0;
          end else if (r.excl_v && f == r.excl) begin
            k++;
          end else begin
            age_q.delete(k);
            age_q.push_back(f);
            vic = f;
            got = 1;
          end
        end
      end else if (pol == frp_pkg::PolicyLru) begin
        if (r.excl_v) stamp[r.excl] = r.now - 32'd1;
        for (int i = 0; i < frp_pkg::NumFrames; i++) begin
          if (!(shr[i] || (r.excl_v && i == r.excl))) begin
            if (!got || stamp[i] < best) begin
              best = stamp[i];
              vic = i;
              got = 1;
            end
          end
        end
        if (got) stamp[vic] = r.now;
      end else if (pol == frp_pkg::PolicyClock) begin
        for (int n = 0; n < 2 * frp_pkg::NumFrames && !got; n++) begin
          if (!refb[hand] && !shr[hand] && !(r.excl_v && hand == r.excl)) begin
            refb[hand] = 1;
            vic = hand;
            got = 1;
          end else begin
            refb[hand] = 0;
          end
          hand = (hand + 1) % frp_pkg::NumFrames;
        end
      end
      if (got) begin
        g.vowner = own_tab[vic];
        g.vpage = page_tab[vic];
        own_tab[vic] = r.owner;
        page_tab[vic] = r.page;
        g.frame = 5'(vic);
        g.status = frp_pkg::StatusVictim;
      end
    end else begin
      g.frame = r.tgt;
      if (occ[r.tgt]) begin
        g.status = frp_pkg::StatusDone;
        if (r.mode == frp_pkg::ModeRelease) begin
          occ[r.tgt] = 0; refb[r.tgt] = 0; shr[r.tgt] = 0;
          if (queued[r.tgt]) begin
            for (int i = 0; i < age_q.size(); i++) begin
              if (age_q[i] == r.tgt) begin
                age_q.delete(i);
                break;
              end
            end
            queued[r.tgt] = 0;
          end
        end else if (r.mode == frp_pkg::ModeTouch) begin
          refb[r.tgt] = 1;
          stamp[r.tgt] = r.now;
        end else begin
          shr[r.tgt] = 1;
        end
      end
    end
    return g;
  endfunction

  task automatic idle_burst();
    if (!quiet && $urandom_range(3) == 0) repeat ($urandom_range(10, 1)) @(posedge clk_i);
  endtask

  // Sends one request and queues its predicted grant when it is taken.
  task automatic send_request(request_t r);
    grant_t g;
    idle_burst();
    mode_i <= r.mode; owner_id_i <= r.owner; virtual_page_i <= r.page;
    excluded_frame_i <= r.excl; exclude_valid_i <= r.excl_v;
    target_frame_i <= r.tgt; current_time_i <= r.now;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    g = allocate_or_maintain(r);
    expected_grants.push_back(g);
    typed_valid.push_back(r.check_exp);
    typed_grants.push_back('{frame: r.exp_frame, status: r.exp_status,
                             vowner: '0, vpage: '0});
    in_valid_i <= 1'b0;
    // The core stalls after taking a request.
    @(posedge clk_i);
  endtask

  // Writes the policy register while the core is idle.
  task automatic set_policy(logic [1:0] p);
    wait (expected_grants.size() == 0);
    repeat (80) @(posedge clk_i);
    cfg_data_i <= p;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pol = p;
  endtask

  function automatic request_t mk(logic [1:0] m, logic [4:0] tgt, logic [4:0] ex,
                                  logic exv, logic [31:0] now);
    request_t r;
    r.mode = m; r.owner = 8'($urandom); r.page = 16'($urandom); r.excl = ex;
    r.excl_v = exv;
    r.tgt = tgt; r.now = now; r.check_exp = 0; r.exp_frame = '0; r.exp_status = '0;
    return r;
  endfunction

  // Random request; allocations most often, then release, touch and share of any frame.
  function automatic request_t random_request();
    request_t r;
    int sel;
    sel = $urandom_range(99);
    r = mk(sel < 45 ? frp_pkg::ModeAlloc : sel < 65 ? frp_pkg::ModeRelease :
           sel < 85 ? frp_pkg::ModeTouch : frp_pkg::ModeShare,
           5'($urandom), 5'($urandom), 1'($urandom_range(1)), $urandom);
    return r;
  endfunction

  // Result side: field-by-field checking of each grant.
  always @(posedge clk_i) begin
    grant_t g;
    if (out_valid_o && !out_stall_i && rst_ni) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected grant frame=%0d status=%0d", $time, frame_o, status_o);
        failed = 1'b1;
      end else begin
        g = expected_grants.pop_front();
        if (typed_valid.pop_front()) begin
          // Directed rows also carry an at-a-glance expectation.
          if (typed_grants[0].frame != g.frame || typed_grants[0].status != g.status) begin
            $display("%0t: table row expected frame=%0d status=%0d, predictor %0d/%0d",
                     $time, typed_grants[0].frame, typed_grants[0].status,
                     g.frame, g.status);
            failed = 1'b1;
          end
        end
        void'(typed_grants.pop_front());
        if (frame_o !== g.frame) begin
          $display("%0t: frame expected %0d actual %0d", $time, g.frame, frame_o);
          failed = 1'b1;
        end
        if (status_o !== g.status) begin
          $display("%0t: status expected %0d actual %0d", $time, g.status, status_o);
          failed = 1'b1;
        end
        if (victim_owner_o !== g.vowner) begin
          $display("%0t: victim_owner expected %0h actual %0h", $time, g.vowner,
                   victim_owner_o);
          failed = 1'b1;
        end
        if (victim_page_o !== g.vpage) begin
          $display("%0t: victim_page expected %0h actual %0h", $time, g.vpage,
                   victim_page_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Stall bursts on the result side.
  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(10, 1)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    request_t dir_tab[$];
    request_t r;
    logic [1:0] phases[6];
    predictor_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: empty core status, first allocations, extremes.
    r = mk(frp_pkg::ModeRelease, 5'd31, 5'd0, 1'b0, 32'd0); r.check_exp = 1;
    r.exp_frame = 5'd31; r.exp_status = frp_pkg::StatusNone; dir_tab.push_back(r);
    r = mk(frp_pkg::ModeTouch, 5'd0, 5'd0, 1'b0, 32'd0); r.check_exp = 1;
    r.exp_frame = 5'd0; r.exp_status = frp_pkg::StatusNone; dir_tab.push_back(r);
    r = mk(frp_pkg::ModeShare, 5'd0, 5'd0, 1'b0, 32'd0); r.check_exp = 1;
    r.exp_frame = 5'd0; r.exp_status = frp_pkg::StatusNone; dir_tab.push_back(r);
    r = mk(frp_pkg::ModeAlloc, 5'd0, 5'd31, 1'b1, 32'hFFFF_FFFF);
    r.owner = 8'hFF; r.page = 16'hFFFF;
    r.check_exp = 1; r.exp_frame = 5'd0; r.exp_status = frp_pkg::StatusDone;
    dir_tab.push_back(r);
    r = mk(frp_pkg::ModeAlloc, 5'd0, 5'd0, 1'b0, 32'd0); r.owner = '0; r.page = '0;
    r.check_exp = 1; r.exp_frame = 5'd1; r.exp_status = frp_pkg::StatusDone;
    dir_tab.push_back(r);
    r = mk(frp_pkg::ModeTouch, 5'd1, 5'd0, 1'b0, 32'h0); dir_tab.push_back(r);
    r = mk(frp_pkg::ModeShare, 5'd1, 5'd0, 1'b0, 32'd0); dir_tab.push_back(r);
    r = mk(frp_pkg::ModeRelease, 5'd1, 5'd0, 1'b0, 32'd0); r.check_exp = 1;
    r.exp_frame = 5'd1; r.exp_status = frp_pkg::StatusDone; dir_tab.push_back(r);
    for (int i = 0; i < 17; i++) begin
      dir_tab.push_back(mk(frp_pkg::ModeAlloc, 5'd0, 5'd3, 1'b1, 32'(i)));
    end
    foreach (dir_tab[i]) send_request(dir_tab[i]);

    // Fill the core, then run every policy (unused value too) with victims.
    phases = '{frp_pkg::PolicyFifo, frp_pkg::PolicyLru, frp_pkg::PolicyClock, 2'd3,
               frp_pkg::PolicyLru, frp_pkg::PolicyFifo};
    for (int p = 0; p < 6; p++) begin
      set_policy(phases[p]);
      if (p == 5) quiet = 1'b1;
      for (int n = 0; n < 250; n++) send_request(random_request());
    end
    // Close with a full-table sweep: everything shared gives no eligible frame.
    set_policy(frp_pkg::PolicyClock);
    for (int i = 0; i < frp_pkg::NumFrames; i++) begin
      send_request(mk(frp_pkg::ModeAlloc, 5'd0, 5'd0, 1'b0, 32'd0));
    end
    for (int i = 0; i < frp_pkg::NumFrames; i++) begin
      send_request(mk(frp_pkg::ModeShare, 5'(i), 5'd0, 1'b0, 32'd0));
    end
    send_request(mk(frp_pkg::ModeAlloc, 5'd0, 5'd0, 1'b0, 32'd0));

    wait (expected_grants.size() == 0);
    repeat (100) @(posedge clk_i);
    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Generous watchdog for about 1600 requests.
  initial begin
    #40000000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
